// File: sv/zjid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Zeno jump interval detector: shared types and constants
// Controller states, command and status bundles, and fixed field widths.
// ----------------------------------------------------------------------------
package zjid_pkg;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 64;
   localparam int OUT_TIME_W  = 48;
   localparam int LIMIT_W     = 32;
   localparam int COUNT_W     = 4;
   localparam int CHUNK_W     = 16;
   localparam int RSP_USED_W  = 1 + COUNT_W + COUNT_W + 1 + OUT_TIME_W + 1;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PREP,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic walk;
      logic prep;
      logic mul;
      logic div_init;
      logic div;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic mul_last;
      logic div_last;
   } sts_type;

endpackage
`default_nettype wire

// File: sv/zjid_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Zeno jump interval detector: datapath
// Timestamp ring, gap walk with shrink and tiny counts, chunked multiplier,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module zjid_datapath
   import zjid_pkg::*;
#(
   parameter int WINDOW    = 10,
   parameter int TIME_BITS = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output      sts_type               sts,
   input  wire logic [REQ_DATA_W-1:0] jump_time,
   input  wire logic                  new_run,
   input  wire logic                  csr_we,
   input  wire logic [LIMIT_W-1:0]    csr_data,
   output      logic [RSP_DATA_W-1:0] rsp_data
);

   localparam int TW  = (TIME_BITS < OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;
   localparam int SW  = $clog2(WINDOW);
   localparam int CW  = $clog2(WINDOW + 1);
   localparam int IW  = CW + 1;
   localparam int NC  = (TW + CHUNK_W - 1) / CHUNK_W;
   localparam int MW  = NC * CHUNK_W;
   localparam int AW  = TW + MW;
   localparam int PW  = TW + CHUNK_W;
   localparam int LW  = (TW > LIMIT_W) ? TW : LIMIT_W;
   localparam int SX  = TW + 6;
   localparam int MCW = (NC > 1) ? $clog2(NC) : 1;
   localparam int DCW = $clog2(TW);

   logic [TW-1:0]        mem [WINDOW];

   logic [CW-1:0]        jc_ff;
   logic [SW-1:0]        ws_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [CW-1:0]        rd_left_ff;
   logic                 rd_vld_ff;
   logic                 gap_vld_ff;
   logic                 have_t_ff;
   logic                 have_p_ff;

   logic [SW-1:0]        rd_slot_ff;
   logic [TW-1:0]        rd_data_ff;
   logic                 full_ff;
   logic [TW-1:0]        t0_ff;
   logic [TW-1:0]        t1_ff;
   logic [TW-1:0]        t2_ff;
   logic signed [TW:0]   gap_ff;
   logic signed [SX-1:0] p19_ff;
   logic [CW-1:0]        shrink_ff;
   logic [CW-1:0]        tiny_ff;
   logic [TW:0]          d1_ff;
   logic [TW:0]          d2_ff;
   logic [MW-1:0]        mcand_ff;
   logic [AW-1:0]        acc_ff;
   logic [MCW-1:0]       mcnt_ff;
   logic [TW-1:0]        divisor_ff;
   logic                 est_ok_ff;
   logic [TW-1:0]        rem_ff;
   logic [TW-1:0]        quo_ff;
   logic                 big_ff;
   logic [DCW-1:0]       dcnt_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [SW-1:0]        wr_slot;
   logic [CW-1:0]        jc_base;
   logic [SW-1:0]        ws_in;
   logic [CW-1:0]        jc_in;
   logic [IW-1:0]        ws_wide;
   logic [IW-1:0]        jc_wide;
   logic [IW-1:0]        start_wide;
   logic [SW-1:0]        rd_slot_in;
   logic signed [TW:0]   gap_in;
   logic signed [SX-1:0] g_ext;
   logic signed [SX-1:0] g20;
   logic signed [SX-1:0] p19_in;
   logic                 shrink_hit;
   logic                 tiny_hit;
   logic [TW:0]          d1_in;
   logic [TW:0]          d2_in;
   logic [TW:0]          dd;
   logic [PW-1:0]        pp;
   logic [AW-1:0]        acc_in;
   logic [TW:0]          shifted;
   logic                 ge;
   logic [TW:0]          sum;
   logic                 clip;
   logic [TW-1:0]        acc_time;
   logic                 zeno;
   logic [COUNT_W-1:0]   shrink_out;
   logic [COUNT_W-1:0]   tiny_out;

   always_comb begin
      wr_slot    = new_run ? '0 : ws_ff;
      jc_base    = new_run ? '0 : jc_ff;
      ws_in      = (wr_slot == SW'(WINDOW - 1)) ? '0 : wr_slot + SW'(1);
      jc_in      = (jc_base == CW'(WINDOW)) ? jc_base : jc_base + CW'(1);
      ws_wide    = IW'(ws_in);
      jc_wide    = IW'(jc_in);
      start_wide = (ws_wide >= jc_wide) ? ws_wide - jc_wide
                                        : ws_wide + IW'(WINDOW) - jc_wide;
      rd_slot_in = (rd_slot_ff == SW'(WINDOW - 1)) ? '0 : rd_slot_ff + SW'(1);

      gap_in     = $signed({1'b0, rd_data_ff}) - $signed({1'b0, t2_ff});
      g_ext      = SX'(gap_ff);
      g20        = (g_ext <<< 4) + (g_ext <<< 2);
      p19_in     = (g_ext <<< 4) + (g_ext <<< 1) + g_ext;
      shrink_hit = !have_p_ff || (g20 < p19_ff);
      tiny_hit   = gap_ff[TW] || (LW'(gap_ff[TW-1:0]) < LW'(limit_ff));

      d1_in      = {1'b0, t1_ff} - {1'b0, t0_ff};
      d2_in      = {1'b0, t2_ff} - {1'b0, t1_ff};
      dd         = d1_ff - d2_ff;
      pp         = PW'(d1_ff[TW-1:0]) * PW'(mcand_ff[MW-1 -: CHUNK_W]);
      acc_in     = (acc_ff << CHUNK_W) + AW'(pp);

      shifted    = {rem_ff, quo_ff[TW-1]};
      ge         = shifted >= {1'b0, divisor_ff};

      sum        = {1'b0, t2_ff} + {1'b0, quo_ff};
      clip       = big_ff || sum[TW];
      acc_time   = !est_ok_ff ? '0 : (clip ? {TW{1'b1}} : sum[TW-1:0]);
      zeno       = full_ff && ((8'(shrink_ff) >= 8'(WINDOW - 2)) ||
                               (8'(tiny_ff) >= 8'(WINDOW / 2)));
      shrink_out = (8'(shrink_ff) > 8'd15) ? 4'hF : COUNT_W'(shrink_ff);
      tiny_out   = (8'(tiny_ff) > 8'd15) ? 4'hF : COUNT_W'(tiny_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jc_ff      <= '0;
         ws_ff      <= '0;
         limit_ff   <= LIMIT_W'(1);
         rd_left_ff <= '0;
         rd_vld_ff  <= 1'b0;
         gap_vld_ff <= 1'b0;
         have_t_ff  <= 1'b0;
         have_p_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_data;
         end
         if (cmd.start) begin
            jc_ff      <= jc_in;
            ws_ff      <= ws_in;
            rd_left_ff <= jc_in;
            rd_vld_ff  <= 1'b0;
            gap_vld_ff <= 1'b0;
            have_t_ff  <= 1'b0;
            have_p_ff  <= 1'b0;
         end else if (cmd.walk) begin
            rd_vld_ff  <= (rd_left_ff != '0);
            gap_vld_ff <= rd_vld_ff && have_t_ff;
            if (rd_left_ff != '0) begin
               rd_left_ff <= rd_left_ff - CW'(1);
            end
            if (rd_vld_ff) begin
               have_t_ff <= 1'b1;
            end
            if (gap_vld_ff) begin
               have_p_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mem[wr_slot] <= jump_time[TW-1:0];
      end
      if (cmd.walk && (rd_left_ff != '0)) begin
         rd_data_ff <= mem[rd_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_slot_ff <= SW'(start_wide);
         full_ff    <= (jc_in == CW'(WINDOW));
         shrink_ff  <= '0;
         tiny_ff    <= '0;
      end
      if (cmd.walk) begin
         if (rd_left_ff != '0) begin
            rd_slot_ff <= rd_slot_in;
         end
         if (rd_vld_ff) begin
            t0_ff  <= t1_ff;
            t1_ff  <= t2_ff;
            t2_ff  <= rd_data_ff;
            gap_ff <= gap_in;
         end
         if (gap_vld_ff) begin
            p19_ff <= p19_in;
            if (full_ff && shrink_hit) begin
               shrink_ff <= shrink_ff + CW'(1);
            end
            if (full_ff && tiny_hit) begin
               tiny_ff <= tiny_ff + CW'(1);
            end
         end
      end
      if (cmd.prep) begin
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         mcand_ff <= MW'(d2_in[TW-1:0]);
         acc_ff   <= '0;
         mcnt_ff  <= '0;
      end
      if (cmd.mul) begin
         acc_ff     <= acc_in;
         mcand_ff   <= mcand_ff << CHUNK_W;
         mcnt_ff    <= mcnt_ff + MCW'(1);
         divisor_ff <= dd[TW-1:0];
         est_ok_ff  <= (jc_ff >= CW'(3)) && !d1_ff[TW] && (d1_ff != '0) &&
                       !d2_ff[TW] && (d2_ff != '0) && !dd[TW] && (dd != '0);
      end
      if (cmd.div_init) begin
         rem_ff  <= acc_ff[2*TW-1:TW];
         quo_ff  <= acc_ff[TW-1:0];
         big_ff  <= acc_ff[2*TW-1:TW] >= divisor_ff;
         dcnt_ff <= '0;
      end
      if (cmd.div) begin
         rem_ff  <= ge ? TW'(shifted - {1'b0, divisor_ff}) : shifted[TW-1:0];
         quo_ff  <= {quo_ff[TW-2:0], ge};
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
      if (cmd.load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, est_ok_ff && clip,
                         OUT_TIME_W'(acc_time), est_ok_ff,
                         tiny_out, shrink_out, zeno};
      end
   end

   assign sts.walk_done = (rd_left_ff == '0) && !rd_vld_ff && !gap_vld_ff;
   assign sts.mul_last  = (mcnt_ff == MCW'(NC - 1));
   assign sts.div_last  = (dcnt_ff == DCW'(TW - 1));
   assign rsp_data      = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      IW'(ws_ff) < IW'(WINDOW))
      else $error("write slot outside the ring");
   assert property (@(posedge clock) disable iff (reset)
      IW'(jc_ff) <= IW'(WINDOW))
      else $error("jump count beyond the window");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ((rd_left_ff == '0) && !rd_vld_ff && !gap_vld_ff))
      else $error("result loaded before the gap walk drained");

endmodule
`default_nettype wire

// File: sv/zjid_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Zeno jump interval detector: controller
// Sequences accept, gap walk, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module zjid_controller
   import zjid_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      cmd_type cmd,
   input  wire sts_type sts
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               state_in = ST_PREP;
            end else begin
               cmd.walk = 1'b1;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (sts.mul_last) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("a second item was taken while one is in flight");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result not presented");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before it was taken");

endmodule
`default_nettype wire

// File: sv/zeno_jump_interval_detector.sv
`default_nettype none
// One item is taken at a time: a new jump is accepted only once the previous result
// is loaded, after the ring walk, the multiply and the one-bit-per-cycle divider.
// The walk is shorter while the ring is filling; TIME_BITS is capped at 48.
// A result left waiting holds the next item.
// Reset (synchronous, active high) empties the history and sets the tiny gap
// limit to 1; the ring contents are not cleared.
// ----------------------------------------------------------------------------
// Zeno jump interval detector
// Keeps the last WINDOW jump times, counts shrinking and tiny gaps, flags Zeno
// behaviour and estimates the accumulation time from the last three jumps.
// ----------------------------------------------------------------------------
module zeno_jump_interval_detector
   import zjid_pkg::*;
#(
   parameter int WINDOW    = 10,
   parameter int TIME_BITS = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // jump_time[47:0]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // new_run
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // zeno_detected[0], shrinking_gaps[4:1], tiny_gaps[8:5], estimate_valid[9],
   // accumulation_time[57:10], estimate_clipped[58], zero[63:59]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [LIMIT_W-1:0]    csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   zjid_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   zjid_datapath #(
      .WINDOW    (WINDOW),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .jump_time (req_tdata),
      .new_run   (req_tuser),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the Zeno jump interval detector
// Streams jump times through the block under bursty input and a stalling
// output. A built-in predictor works out every result. The tiny gap limit is
// changed between phases, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb;
   import zjid_pkg::*;

   localparam int WINDOW = 10;
   localparam int STALL_LIMIT = 5000;
   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [REQ_DATA_W-1:0] jump_time;
      logic                  new_run;
   } jump_item_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]  pad;
      logic                  estimate_clipped;
      logic [OUT_TIME_W-1:0] accumulation_time;
      logic                  estimate_valid;
      logic [COUNT_W-1:0]    tiny_gaps;
      logic [COUNT_W-1:0]    shrinking_gaps;
      logic                  zeno_detected;
   } zeno_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_W-1:0] csr_data = '0;

   jump_item_type pending_jumps[$];
   zeno_verdict_type expected_verdicts[$];

   logic [47:0] jump_ring[WINDOW];
   int held_jumps = 0;
   int ring_slot = 0;
   logic [LIMIT_W-1:0] tiny_limit = 1;

   int error_count = 0;
   int results_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;
   zeno_verdict_type got_verdict, want_verdict;

   zeno_jump_interval_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got_v,
                              input logic [63:0] want_v);
      if (got_v !== want_v) begin
         report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got_v, want_v));
      end
   endtask

   // Records the jump in the ring, then judges the gap window and the estimate.
   function automatic zeno_verdict_type judge_jump(input jump_item_type item);
      zeno_verdict_type v;
      int oldest, shrink_n, tiny_n;
      longint gap, prev_gap, lim;
      logic [47:0] a, b, t0, t1, t2;
      logic [127:0] d1, d2, quot;
      v = '0;
      if (item.new_run) begin
         held_jumps = 0;
         ring_slot = 0;
      end
      jump_ring[ring_slot] = item.jump_time;
      ring_slot = (ring_slot + 1) % WINDOW;
      if (held_jumps < WINDOW) held_jumps++;
      oldest = (ring_slot + WINDOW - held_jumps) % WINDOW;
      if (held_jumps >= WINDOW) begin
         shrink_n = 0;
         tiny_n = 0;
         prev_gap = 0;
         lim = {32'd0, tiny_limit};
         for (int i = 1; i < WINDOW; i++) begin
            a = jump_ring[(oldest + i) % WINDOW];
            b = jump_ring[(oldest + i - 1) % WINDOW];
            gap = $signed({16'd0, a}) - $signed({16'd0, b});
            if (i == 1 || 20 * gap < 19 * prev_gap) shrink_n++;
            if (gap < lim) tiny_n++;
            prev_gap = gap;
         end
         v.zeno_detected = (shrink_n >= WINDOW - 2) || (tiny_n >= WINDOW / 2);
         v.shrinking_gaps = COUNT_W'(shrink_n > 15 ? 15 : shrink_n);
         v.tiny_gaps = COUNT_W'(tiny_n > 15 ? 15 : tiny_n);
      end
      if (held_jumps >= 3) begin
         t0 = jump_ring[(oldest + held_jumps - 3) % WINDOW];
         t1 = jump_ring[(oldest + held_jumps - 2) % WINDOW];
         t2 = jump_ring[(oldest + held_jumps - 1) % WINDOW];
         if (t1 > t0 && t2 > t1 && t2 - t1 < t1 - t0) begin
            d1 = 128'(t1 - t0);
            d2 = 128'(t2 - t1);
            quot = (d1 * d2) / (d1 - d2);
            v.estimate_valid = 1'b1;
            if (quot > 128'(TIME_MAX - 64'(t2))) begin
               v.estimate_clipped = 1'b1;
               v.accumulation_time = TIME_MAX[47:0];
            end else begin
               v.accumulation_time = t2 + quot[47:0];
            end
         end
      end
      return v;
   endfunction

   task automatic queue_jump(input logic fresh, input logic [47:0] t);
      jump_item_type it;
      it.new_run = fresh;
      it.jump_time = t;
      pending_jumps.push_back(it);
   endtask

   function automatic logic [63:0] pick_gap();
      logic [63:0] r, g;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: g = 64'($urandom_range(0, 3));
         1: begin
            g = {32'd0, tiny_limit} + 64'($urandom_range(0, 4));
            g = g < 2 ? 64'd0 : g - 64'd2;
         end
         2: g = r >> $urandom_range(16, 63);
         default: g = (64'd1 << 46) + (r >> 18);
      endcase
      return g;
   endfunction

   // Runs of jumps with shrinking or growing, limit-near, even or arbitrary spacing.
   task automatic queue_random_jumps(input int target);
      int made, run_len, style, ratio;
      logic [63:0] t, gap;
      logic fresh;
      made = 0;
      while (made < target) begin
         run_len = $urandom_range(1, 24);
         style = $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0: t = 64'($urandom_range(0, 1000));
            1: t = TIME_MAX - 64'($urandom_range(0, 1 << 20));
            default: t = {$urandom, $urandom} & TIME_MAX;
         endcase
         gap = pick_gap();
         for (int k = 0; k < run_len; k++) begin
            fresh = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 63) == 0);
            if (style == 9) begin
               t = {$urandom, $urandom} & TIME_MAX;
               fresh = ($urandom_range(0, 1) != 0);
            end
            queue_jump(fresh, t[47:0]);
            if (style <= 4) begin
               ratio = $urandom_range(17, 21);
               if (ratio == 19) gap = gap - gap % 64'd20;
               gap = gap * 64'(ratio) / 64'd20;
            end else if (style <= 6) begin
               gap = pick_gap();
            end
            if ($urandom_range(0, 15) == 0) t = t - pick_gap();
            else t = t + gap;
            t = t & TIME_MAX;
         end
         made += run_len;
      end
   endtask

   task automatic wait_drained();
      while (pending_jumps.size() != 0 || expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tiny_limit = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_verdicts.push_back(judge_jump(pending_jumps.pop_front()));
            if (burst_left > 0) burst_left--;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_jumps.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_jumps[0].jump_time;
               req_tuser <= pending_jumps[0].new_run;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_verdicts.size() == 0) begin
               report_error($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
            end else begin
               got_verdict = rsp_tdata;
               want_verdict = expected_verdicts.pop_front();
               check_field("zeno_detected", 64'(got_verdict.zeno_detected),
                           64'(want_verdict.zeno_detected));
               check_field("shrinking_gaps", 64'(got_verdict.shrinking_gaps),
                           64'(want_verdict.shrinking_gaps));
               check_field("tiny_gaps", 64'(got_verdict.tiny_gaps),
                           64'(want_verdict.tiny_gaps));
               check_field("estimate_valid", 64'(got_verdict.estimate_valid),
                           64'(want_verdict.estimate_valid));
               check_field("accumulation_time", 64'(got_verdict.accumulation_time),
                           64'(want_verdict.accumulation_time));
               check_field("estimate_clipped", 64'(got_verdict.estimate_clipped),
                           64'(want_verdict.estimate_clipped));
               check_field("padding", 64'(got_verdict.pad), 64'(want_verdict.pad));
            end
         end
         // A single long hold-off lets the block back up and stall its input.
         if (!hold_done && results_seen == 60) begin
            hold_done = 1'b1;
            hold_left = 600;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) != 0);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] t, step;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The quotient overflows and the estimate saturates.
      queue_jump(1'b1, 48'h0);
      queue_jump(1'b0, 48'h8000_0000_0000);
      queue_jump(1'b0, 48'hFFFF_FFFF_FFFF);
      // The quotient fits but the sum passes the maximum time.
      queue_jump(1'b1, 48'hFFFF_FFFF_F060);
      queue_jump(1'b0, 48'hFFFF_FFFF_F448);
      queue_jump(1'b0, 48'hFFFF_FFFF_F7CC);
      t = 0;
      step = 1000;
      for (int k = 0; k < WINDOW; k++) begin
         queue_jump(k == 0, t[47:0]);
         if (k < WINDOW - 1) begin
            t = t + step;
            step = step * 64'd9 / 64'd10;
         end
      end
      queue_jump(1'b0, t[47:0]);
      queue_jump(1'b0, 48'd100);
      queue_jump(1'b0, 48'd100);
      queue_jump(1'b0, 48'hFFFF_FFFF_FFFF);
      queue_jump(1'b0, 48'd0);
      queue_jump(1'b0, 48'd0);
      queue_jump(1'b0, 48'd10);
      queue_jump(1'b0, 48'd20);
      wait_drained();

      write_limit(32'd0);
      queue_random_jumps(100);
      wait_drained();
      write_limit(32'hFFFF_FFFF);
      queue_random_jumps(70);
      wait_drained();
      write_limit(32'd1000);
      queue_random_jumps(130);
      wait_drained();
      write_limit($urandom);
      queue_random_jumps(80);
      wait_drained();
      write_limit(32'd50);
      queue_random_jumps(80);
      wait_drained();

      repeat (100) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         report_error($sformatf("%0d results never arrived", expected_verdicts.size()));
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
sv/zjid_pkg.sv
sv/zjid_datapath.sv
sv/zjid_controller.sv
sv/zeno_jump_interval_detector.sv
dv/tb.sv
